// ----- hdl/rect_window_polygon_clipper_core_assert.svh -----
// Assertion macros for the clipper RTL, included by rwpc_cell.
// Expects clock aclk and active-low reset aresetn in the including module.
`ifndef RECT_WINDOW_POLYGON_CLIPPER_CORE_ASSERT_SVH
`define RECT_WINDOW_POLYGON_CLIPPER_CORE_ASSERT_SVH

// same-cycle implication
`define RWPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rwpc_pkg.sv -----
// Package for the rectangular window polygon clipper.
// Types, widths, side and register codes and helpers; no dependencies.
package rwpc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int Q_BITS     = COORD_BITS + FRAC_BITS;
    localparam int D_BITS     = Q_BITS + 1;
    localparam int P_BITS     = 2 * D_BITS;
    localparam int NUM_BITS   = P_BITS + 3;
    localparam int DEN_BITS   = D_BITS + 1;
    localparam int QUO_BITS   = D_BITS;
    localparam int CNT_BITS   = $clog2(QUO_BITS);
    localparam int N_CELLS    = 4;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         final_vertex;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_BITS-1:0] clipped_x;
        logic signed [Q_BITS-1:0] clipped_y;
        logic                     vertex_present;
        logic                     polygon_end;
    } out_item_t;

    // vtx: carries a vertex; fin: close the polygon after it
    typedef struct packed {
        logic signed [Q_BITS-1:0] x;
        logic signed [Q_BITS-1:0] y;
        logic                     vtx;
        logic                     fin;
    } tok_t;

    function automatic logic signed [D_BITS-1:0] q_diff(
        input logic signed [Q_BITS-1:0] a,
        input logic signed [Q_BITS-1:0] b
    );
        q_diff = {a[Q_BITS-1], a} - {b[Q_BITS-1], b};
    endfunction

    function automatic logic [D_BITS-1:0] q_mag(input logic signed [D_BITS-1:0] v);
        q_mag = v[D_BITS-1] ? D_BITS'(-v) : D_BITS'(v);
    endfunction

    function automatic logic pt_in(
        input logic [1:0]               side,
        input logic signed [Q_BITS-1:0] bound,
        input logic signed [Q_BITS-1:0] x,
        input logic signed [Q_BITS-1:0] y
    );
        case (side)
            SIDE_LEFT:   pt_in = x >= bound;
            SIDE_RIGHT:  pt_in = x <= bound;
            SIDE_BOTTOM: pt_in = y >= bound;
            default:     pt_in = y <= bound;
        endcase
    endfunction

endpackage

// ----- hdl/rect_window_polygon_clipper_core.sv -----
// Polygon clipper against a rectangular window: four chained clipping cells.
// Depends on rwpc_pkg, rwpc_cell and rwpc_sink.
//
// Usage: vertices enter on s_valid/s_ready/s_data, one transaction each, the
// last of a polygon with final_vertex set. Clipped vertices leave in Q16.8 on
// m_valid/m_ready/m_data; the last result of a polygon has polygon_end set,
// and a polygon clipped away gives one result with vertex_present clear.
// Window sides are written over the APB port (left 0x0, bottom 0x4,
// right 0x8, top 0xC); the user must write them only while no polygon is
// in flight, and the block does not enforce this. pready is always high.
// Each cell tests an edge against its boundary; an edge that crosses it
// also goes through a multiply and a bit-serial divide for the crossing
// point. A cell takes a new token only after it has handed on all results
// of the last one, so the cost of a vertex depends on crossings downstream.
// Results trail by one vertex: a vertex is shown once the next one, or the
// polygon end, reaches the output stage. A stall on m_ready holds the output
// register and backs up the cells in turn. Reset clears the cells' control
// state and loads the default window 0..639 by 0..479.
module rect_window_polygon_clipper_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rwpc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rwpc_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rwpc_pkg::*;

    logic signed [COORD_BITS-1:0] win_reg [N_CELLS];
    logic [1:0]                   widx;
    logic                         wr_en;

    tok_t tok   [N_CELLS+1];
    logic tvld  [N_CELLS+1];
    logic trdy  [N_CELLS+1];

    assign pready = 1'b1;
    assign widx   = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign prdata = 32'(win_reg[widx]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[REG_LEFT]   <= COORD_BITS'(0);
            win_reg[REG_BOTTOM] <= COORD_BITS'(0);
            win_reg[REG_RIGHT]  <= COORD_BITS'(639);
            win_reg[REG_TOP]    <= COORD_BITS'(479);
        end else if (wr_en) begin
            win_reg[widx] <= pwdata[COORD_BITS-1:0];
        end
    end

    assign tok[0].x   = {s_data.vertex_x, {FRAC_BITS{1'b0}}};
    assign tok[0].y   = {s_data.vertex_y, {FRAC_BITS{1'b0}}};
    assign tok[0].vtx = 1'b1;
    assign tok[0].fin = s_data.final_vertex;
    assign tvld[0]    = s_valid;
    assign s_ready    = trdy[0];

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        logic [1:0]               side;
        logic signed [Q_BITS-1:0] bound;

        assign side = 2'(i);

        always_comb begin
            case (side)
                SIDE_LEFT:   bound = {win_reg[REG_LEFT],   {FRAC_BITS{1'b0}}};
                SIDE_RIGHT:  bound = {win_reg[REG_RIGHT],  {FRAC_BITS{1'b0}}};
                SIDE_BOTTOM: bound = {win_reg[REG_BOTTOM], {FRAC_BITS{1'b0}}};
                default:     bound = {win_reg[REG_TOP],    {FRAC_BITS{1'b0}}};
            endcase
        end

        rwpc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .side      (side),
            .bound     (bound),
            .in_valid  (tvld[i]),
            .in_ready  (trdy[i]),
            .in_tok    (tok[i]),
            .out_valid (tvld[i+1]),
            .out_ready (trdy[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    rwpc_sink u_sink (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (tvld[N_CELLS]),
        .in_ready (trdy[N_CELLS]),
        .in_tok   (tok[N_CELLS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- hdl/rwpc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on rwpc_pkg for operand widths.
module rwpc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rwpc_pkg::NUM_BITS-1:0] num,
    input  logic [rwpc_pkg::DEN_BITS-1:0] den,
    output logic                         done,
    output logic [rwpc_pkg::QUO_BITS-1:0] quot
);
    import rwpc_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [QUO_BITS-1:0] sh_reg;
    logic [DEN_BITS:0]   trial;
    logic                ge;

    assign trial = {rem_reg, sh_reg[QUO_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUO_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
            sh_reg  <= num[QUO_BITS-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_BITS'(trial - {1'b0, den_reg}) : DEN_BITS'(trial);
            sh_reg  <= {sh_reg[QUO_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- hdl/rwpc_cell.sv -----
// One clipping cell: clips the token stream against a single window side.
// Depends on rwpc_pkg, rwpc_div and the assertion macro header.
`include "rect_window_polygon_clipper_core_assert.svh"

module rwpc_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    side,
    input  logic signed [rwpc_pkg::Q_BITS-1:0] bound,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rwpc_pkg::tok_t                in_tok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rwpc_pkg::tok_t                out_tok
);
    import rwpc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EVAL  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_DSTRT = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_EMITC = 4'd5;
    localparam logic [3:0] ST_EMITP = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_EMITE = 4'd8;

    logic [3:0]               state_reg;
    logic                     started_reg;
    logic                     closing_reg;
    logic                     fin_reg;
    logic                     pin_reg;
    logic signed [Q_BITS-1:0] pt_x_reg, pt_y_reg;
    logic signed [Q_BITS-1:0] prior_x_reg, prior_y_reg;
    logic signed [Q_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [Q_BITS-1:0] base_reg;
    logic signed [Q_BITS-1:0] cross_reg;
    logic [D_BITS-1:0]        amag_reg, bmag_reg, dmag_reg;
    logic                     neg_reg;
    logic [P_BITS-1:0]        prod_reg;

    logic                     axis_y;
    logic                     s_in, p_in;
    logic signed [D_BITS-1:0] da, db, dd;
    logic                     div_start, div_done;
    logic [QUO_BITS-1:0]      quot;
    logic signed [D_BITS:0]   qs;
    logic signed [D_BITS:0]   cross_sum;

    assign axis_y = side[1];
    assign s_in   = pt_in(side, bound, prior_x_reg, prior_y_reg);
    assign p_in   = pt_in(side, bound, pt_x_reg, pt_y_reg);

    always_comb begin
        if (axis_y) begin
            da = q_diff(pt_x_reg, prior_x_reg);
            db = q_diff(bound, prior_y_reg);
            dd = q_diff(pt_y_reg, prior_y_reg);
        end else begin
            da = q_diff(pt_y_reg, prior_y_reg);
            db = q_diff(bound, prior_x_reg);
            dd = q_diff(pt_x_reg, prior_x_reg);
        end
    end

    assign div_start = state_reg == ST_DSTRT;
    assign qs        = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign cross_sum = {{2{base_reg[Q_BITS-1]}}, base_reg} + qs;

    rwpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({2'b00, prod_reg, 1'b0} + NUM_BITS'(dmag_reg)),
        .den     ({dmag_reg, 1'b0}),
        .done    (div_done),
        .quot    (quot)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = (state_reg == ST_EMITC) || (state_reg == ST_EMITP)
                    || (state_reg == ST_EMITE);

    always_comb begin
        case (state_reg)
            ST_EMITC: begin
                out_tok.x   = axis_y ? cross_reg : bound;
                out_tok.y   = axis_y ? bound : cross_reg;
                out_tok.vtx = 1'b1;
                out_tok.fin = 1'b0;
            end
            ST_EMITP: begin
                out_tok.x   = pt_x_reg;
                out_tok.y   = pt_y_reg;
                out_tok.vtx = 1'b1;
                out_tok.fin = 1'b0;
            end
            default: begin
                out_tok.x   = '0;
                out_tok.y   = '0;
                out_tok.vtx = 1'b0;
                out_tok.fin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            closing_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        closing_reg <= !in_tok.vtx;
                        state_reg   <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (!closing_reg && !started_reg) begin
                        started_reg <= 1'b1;
                        state_reg   <= ST_NEXT;
                    end else if (closing_reg && !started_reg) begin
                        state_reg <= ST_EMITE;
                    end else if (s_in != p_in) begin
                        state_reg <= ST_MUL;
                    end else if (p_in) begin
                        state_reg <= ST_EMITP;
                    end else begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_MUL:   state_reg <= ST_DSTRT;
                ST_DSTRT: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_EMITC;
                    end
                end
                ST_EMITC: begin
                    if (out_ready) begin
                        state_reg <= pin_reg ? ST_EMITP : ST_NEXT;
                    end
                end
                ST_EMITP: begin
                    if (out_ready) begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (closing_reg) begin
                        state_reg <= ST_EMITE;
                    end else if (fin_reg) begin
                        closing_reg <= 1'b1;
                        state_reg   <= ST_EVAL;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMITE: begin
                    if (out_ready) begin
                        started_reg <= 1'b0;
                        closing_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            pt_x_reg <= in_tok.vtx ? in_tok.x : first_x_reg;
            pt_y_reg <= in_tok.vtx ? in_tok.y : first_y_reg;
            fin_reg  <= in_tok.fin;
        end
        if (state_reg == ST_EVAL) begin
            pin_reg  <= p_in;
            amag_reg <= q_mag(da);
            bmag_reg <= q_mag(db);
            dmag_reg <= q_mag(dd);
            neg_reg  <= da[D_BITS-1] ^ db[D_BITS-1] ^ dd[D_BITS-1];
            base_reg <= axis_y ? prior_x_reg : prior_y_reg;
            if (!closing_reg && !started_reg) begin
                first_x_reg <= pt_x_reg;
                first_y_reg <= pt_y_reg;
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= amag_reg * bmag_reg;
        end
        if (state_reg == ST_DIV && div_done) begin
            cross_reg <= Q_BITS'(cross_sum);
        end
        if (state_reg == ST_NEXT && !closing_reg) begin
            prior_x_reg <= pt_x_reg;
            prior_y_reg <= pt_y_reg;
            if (fin_reg) begin
                pt_x_reg <= first_x_reg;
                pt_y_reg <= first_y_reg;
            end
        end
    end

    `RWPC_ASSERT_NOW(a_div_in_div, div_done, state_reg == ST_DIV, "divider done outside DIV")
    `RWPC_ASSERT_NEXT(a_mul_to_div, state_reg == ST_MUL, state_reg == ST_DSTRT,
                      "multiply not followed by divide start")
    `RWPC_ASSERT_NEXT(a_end_clears, out_valid && out_ready && out_tok.fin, !started_reg,
                      "end transaction left cell started")
    `RWPC_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "cell ready while emitting")

endmodule

// ----- hdl/rwpc_sink.sv -----
// Output stage: holds back one vertex to mark the polygon end, then registers it.
// Depends on rwpc_pkg.
module rwpc_sink (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rwpc_pkg::tok_t       in_tok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rwpc_pkg::out_item_t  m_data
);
    import rwpc_pkg::*;

    logic                     hold_valid_reg;
    logic signed [Q_BITS-1:0] hold_x_reg, hold_y_reg;
    logic                     out_valid_reg;
    out_item_t                out_reg;
    logic                     take;
    logic                     load;

    assign in_ready = !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign load     = take && (hold_valid_reg || in_tok.fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                hold_valid_reg <= in_tok.vtx;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_tok.vtx) begin
            hold_x_reg <= in_tok.x;
            hold_y_reg <= in_tok.y;
        end
        if (load) begin
            out_reg.clipped_x      <= hold_valid_reg ? hold_x_reg : '0;
            out_reg.clipped_y      <= hold_valid_reg ? hold_y_reg : '0;
            out_reg.vertex_present <= hold_valid_reg;
            out_reg.polygon_end    <= in_tok.fin;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
